### rtl/source_packet_counter_top_k_unit_macros.svh
`ifndef SOURCE_PACKET_COUNTER_TOP_K_UNIT_MACROS_SVH
`define SOURCE_PACKET_COUNTER_TOP_K_UNIT_MACROS_SVH
// Same-cycle implication, reset masks the check
`define SPCTK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spctk assertion failed");
// Next-cycle implication, reset masks the check
`define SPCTK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spctk assertion failed");
`endif

### rtl/spctk_pkg.sv
`default_nettype none
package spctk_pkg;
  localparam int unsigned TABLE_ENTRIES  = 256;
  localparam int unsigned IGNORE_ENTRIES = 16;
  localparam int unsigned TOP_COUNT      = 10;
  localparam int unsigned TIDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned IIDX_W = (IGNORE_ENTRIES > 1) ? $clog2(IGNORE_ENTRIES) : 1;
  localparam int unsigned SC_W   = $clog2(TOP_COUNT + 1);
  localparam logic [31:0] NET_MASK  = 32'hFFFF_FF00;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef logic [2:0] req_t;
  localparam req_t REQ_PACKET     = 3'd0;
  localparam req_t REQ_CLR_COUNTS = 3'd1;
  localparam req_t REQ_CLR_IGN    = 3'd2;
  localparam req_t REQ_IGN_ADDR   = 3'd3;
  localparam req_t REQ_IGN_NET    = 3'd4;
  localparam req_t REQ_UNDO       = 3'd5;
  localparam req_t REQ_REPORT     = 3'd6;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_COUNTED  = 3'd0;
  localparam kind_t KIND_OWN      = 3'd1;
  localparam kind_t KIND_IGNORED  = 3'd2;
  localparam kind_t KIND_FULL     = 3'd3;
  localparam kind_t KIND_DONE     = 3'd4;
  localparam kind_t KIND_ENTRY    = 3'd5;
  localparam kind_t KIND_EMPTY    = 3'd6;
  localparam kind_t KIND_IGN_FULL = 3'd7;

  typedef struct packed {
    logic              latch;
    logic              rd_en;
    logic [TIDX_W-1:0] rd_idx;
    logic              scan_clr;
    logic              pkt_commit;
    logic              clr_counts;
    logic              clr_ign;
    logic              ign_add;
    logic              undo;
    logic              rep_start;
    logic              rep_next;
    logic              out_load;
    kind_t             out_kind;
    logic [3:0]        out_rank;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic own;
    logic ignored;
    logic ign_full;
    logic slot_ok;
    logic best_found;
    logic out_busy;
  } dp_sts_t;
endpackage
`default_nettype wire

### rtl/spctk_req_if.sv
`default_nettype none
interface spctk_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] addr;
  modport source (output valid, req_type, addr, input ready);
  modport sink (input valid, req_type, addr, output ready);
endinterface
`default_nettype wire

### rtl/spctk_res_if.sv
`default_nettype none
interface spctk_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] out_addr;
  logic [31:0] count;
  logic [3:0]  rank;
  logic        last;
  modport source (output valid, kind, out_addr, count, rank, last, input ready);
  modport sink (input valid, kind, out_addr, count, rank, last, output ready);
endinterface
`default_nettype wire

### rtl/spctk_dp.sv
`default_nettype none
module spctk_dp import spctk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [31:0] addr_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  spctk_res_if.source      res_o
);
  logic [31:0] own_q, raddr_q;
  req_t        req_q;

  logic [31:0] mem_addr [TABLE_ENTRIES];
  logic [31:0] mem_cnt  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [31:0]       rd_addr_q, rd_cnt_q;
  logic              rd_v_q, rd_pv_q;
  logic [TIDX_W-1:0] rd_idx_q;

  logic              m_found_q, f_found_q;
  logic [TIDX_W-1:0] m_idx_q, f_idx_q;
  logic [31:0]       m_cnt_q;

  logic        best_found_q, first_q;
  logic [63:0] best_q, prev_q;

  logic [31:0]         ig_key_q [IGNORE_ENTRIES];
  logic [IGNORE_ENTRIES-1:0] ig_net_q, ig_v_q;
  logic [IIDX_W-1:0]   last_slot_q;
  logic                last_v_q;

  logic        out_v_q, out_last_q;
  kind_t       out_kind_q;
  logic [31:0] out_addr_q, out_cnt_q;
  logic [3:0]  out_rank_q;

  logic [31:0]       ig_key_in, zmask, new_cnt;
  logic              ig_net_in, ignored, dup_any, free_any, is_ign_req;
  logic [IIDX_W-1:0] dup_idx, free_idx;
  logic              wr_en, wr_addr_en;
  logic [TIDX_W-1:0] wr_idx;
  logic [31:0]       wr_cnt;
  logic [63:0]       rd_key;
  logic              rep_cand, pkt_eval;

  assign ig_net_in  = (req_q == REQ_IGN_NET);
  assign is_ign_req = (req_q == REQ_IGN_ADDR) || (req_q == REQ_IGN_NET);
  assign ig_key_in  = ig_net_in ? (raddr_q & NET_MASK) : raddr_q;
  assign zmask      = ig_net_in ? NET_MASK : 32'hFFFF_FFFF;

  always_comb begin
    ignored  = 1'b0;
    dup_any  = 1'b0;
    free_any = 1'b0;
    dup_idx  = '0;
    free_idx = '0;
    for (int i = IGNORE_ENTRIES - 1; i >= 0; i--) begin
      if (ig_v_q[i] && (ig_net_q[i] ? (ig_key_q[i] == (raddr_q & NET_MASK))
                                    : (ig_key_q[i] == raddr_q))) begin
        ignored = 1'b1;
      end
      if (ig_v_q[i] && (ig_net_q[i] == ig_net_in) && (ig_key_q[i] == ig_key_in)) begin
        dup_any = 1'b1;
        dup_idx = IIDX_W'(i);
      end
      if (!ig_v_q[i]) begin
        free_any = 1'b1;
        free_idx = IIDX_W'(i);
      end
    end
  end

  assign new_cnt  = !m_found_q ? 32'd1 :
                    (m_cnt_q == COUNT_MAX) ? m_cnt_q : m_cnt_q + 32'd1;
  assign rd_key   = {rd_cnt_q, rd_addr_q};
  assign rep_cand = rd_pv_q && (req_q == REQ_REPORT) && rd_v_q && (rd_cnt_q != '0) &&
                    (first_q || (rd_key < prev_q)) && (!best_found_q || (rd_key > best_q));
  assign pkt_eval = rd_pv_q && (req_q == REQ_PACKET);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr_en = 1'b0;
    wr_idx     = rd_idx_q;
    wr_cnt     = '0;
    if (rd_pv_q && is_ign_req && rd_v_q && ((rd_addr_q & zmask) == ig_key_in)) begin
      wr_en = 1'b1;
    end else if (cmd_i.pkt_commit && (m_found_q || f_found_q)) begin
      wr_en      = 1'b1;
      wr_addr_en = !m_found_q;
      wr_idx     = m_found_q ? m_idx_q : f_idx_q;
      wr_cnt     = new_cnt;
    end
  end

  // Table memory (one write and one registered read a cycle) and the unreset datapath registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_cnt[wr_idx] <= wr_cnt;
      if (wr_addr_en) begin
        mem_addr[wr_idx] <= raddr_q;
      end
    end
    if (cmd_i.rd_en) begin
      rd_addr_q <= mem_addr[cmd_i.rd_idx];
      rd_cnt_q  <= mem_cnt[cmd_i.rd_idx];
      rd_v_q    <= valid_q[cmd_i.rd_idx];
      rd_idx_q  <= cmd_i.rd_idx;
    end
    if (cmd_i.latch) begin
      raddr_q <= addr_i;
    end
    if (pkt_eval && rd_v_q && (rd_addr_q == raddr_q) && !m_found_q) begin
      m_idx_q <= rd_idx_q;
      m_cnt_q <= rd_cnt_q;
    end
    if (pkt_eval && !rd_v_q && !f_found_q) begin
      f_idx_q <= rd_idx_q;
    end
    if (rep_cand) begin
      best_q <= rd_key;
    end
    if (cmd_i.rep_next) begin
      prev_q <= best_q;
    end
    if (cmd_i.ign_add && !dup_any) begin
      ig_key_q[free_idx] <= ig_key_in;
    end
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_rank_q <= cmd_i.out_rank;
      out_last_q <= cmd_i.out_last;
      unique case (cmd_i.out_kind)
        KIND_COUNTED: begin
          out_addr_q <= raddr_q;
          out_cnt_q  <= new_cnt;
        end
        KIND_OWN, KIND_IGNORED, KIND_FULL: begin
          out_addr_q <= raddr_q;
          out_cnt_q  <= '0;
        end
        KIND_ENTRY: begin
          out_addr_q <= prev_q[31:0];
          out_cnt_q  <= prev_q[63:32];
        end
        default: begin
          out_addr_q <= '0;
          out_cnt_q  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q        <= '0;
      req_q        <= REQ_PACKET;
      valid_q      <= '0;
      rd_pv_q      <= 1'b0;
      m_found_q    <= 1'b0;
      f_found_q    <= 1'b0;
      best_found_q <= 1'b0;
      first_q      <= 1'b1;
      ig_v_q       <= '0;
      ig_net_q     <= '0;
      last_slot_q  <= '0;
      last_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_q <= cfg_wdata_i;
      end
      if (cmd_i.latch) begin
        req_q <= req_type_i;
      end
      rd_pv_q <= cmd_i.rd_en;
      if (cmd_i.clr_counts) begin
        valid_q <= '0;
      end else if (cmd_i.pkt_commit && !m_found_q && f_found_q) begin
        valid_q[f_idx_q] <= 1'b1;
      end
      if (cmd_i.scan_clr) begin
        m_found_q    <= 1'b0;
        f_found_q    <= 1'b0;
        best_found_q <= 1'b0;
      end else begin
        if (pkt_eval && rd_v_q && (rd_addr_q == raddr_q)) begin
          m_found_q <= 1'b1;
        end
        if (pkt_eval && !rd_v_q) begin
          f_found_q <= 1'b1;
        end
        if (rep_cand) begin
          best_found_q <= 1'b1;
        end
      end
      if (cmd_i.rep_start) begin
        first_q <= 1'b1;
      end else if (cmd_i.rep_next) begin
        first_q <= 1'b0;
      end
      if (cmd_i.clr_ign) begin
        ig_v_q   <= '0;
        last_v_q <= 1'b0;
      end else if (cmd_i.ign_add) begin
        last_v_q <= 1'b1;
        if (dup_any) begin
          last_slot_q <= dup_idx;
        end else begin
          ig_v_q[free_idx]   <= 1'b1;
          ig_net_q[free_idx] <= ig_net_in;
          last_slot_q        <= free_idx;
        end
      end else if (cmd_i.undo) begin
        if (last_v_q) begin
          ig_v_q[last_slot_q] <= 1'b0;
        end
        last_v_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.kind     = out_kind_q;
  assign res_o.out_addr = out_addr_q;
  assign res_o.count    = out_cnt_q;
  assign res_o.rank     = out_rank_q;
  assign res_o.last     = out_last_q;

  always_comb begin
    sts_o            = '0;
    sts_o.req        = req_q;
    sts_o.own        = (raddr_q == own_q);
    sts_o.ignored    = ignored;
    sts_o.ign_full   = !dup_any && !free_any;
    sts_o.slot_ok    = m_found_q || f_found_q;
    sts_o.best_found = best_found_q;
    sts_o.out_busy   = out_v_q && !res_o.ready;
  end
endmodule
`default_nettype wire

### rtl/spctk_ctrl.sv
`default_nettype none
module spctk_ctrl import spctk_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_DRAIN, S_FINISH, S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [TIDX_W-1:0] idx_q, idx_d;
  logic [SC_W-1:0]   sc_q, sc_d;
  kind_t             kind_q, kind_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_idx = idx_q;
    state_d      = state_q;
    idx_d        = idx_q;
    sc_d         = sc_q;
    kind_d       = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.req)
          REQ_PACKET: begin
            if (sts_i.own) begin
              kind_d  = KIND_OWN;
              state_d = S_EMIT;
            end else if (sts_i.ignored) begin
              kind_d  = KIND_IGNORED;
              state_d = S_EMIT;
            end else begin
              cmd_o.scan_clr = 1'b1;
              idx_d          = '0;
              state_d        = S_SCAN;
            end
          end
          REQ_CLR_COUNTS: begin
            cmd_o.clr_counts = 1'b1;
            kind_d           = KIND_DONE;
            state_d          = S_EMIT;
          end
          REQ_CLR_IGN: begin
            cmd_o.clr_ign = 1'b1;
            kind_d        = KIND_DONE;
            state_d       = S_EMIT;
          end
          REQ_IGN_ADDR, REQ_IGN_NET: begin
            if (sts_i.ign_full) begin
              kind_d  = KIND_IGN_FULL;
              state_d = S_EMIT;
            end else begin
              cmd_o.ign_add  = 1'b1;
              cmd_o.scan_clr = 1'b1;
              idx_d          = '0;
              state_d        = S_SCAN;
            end
          end
          REQ_UNDO: begin
            cmd_o.undo = 1'b1;
            kind_d     = KIND_DONE;
            state_d    = S_EMIT;
          end
          REQ_REPORT: begin
            cmd_o.rep_start = 1'b1;
            cmd_o.scan_clr  = 1'b1;
            idx_d           = '0;
            sc_d            = '0;
            state_d         = S_SCAN;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + TIDX_W'(1);
        if (idx_q == TIDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          unique case (sts_i.req)
            REQ_PACKET: begin
              cmd_o.pkt_commit = 1'b1;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_kind   = sts_i.slot_ok ? KIND_COUNTED : KIND_FULL;
              cmd_o.out_last   = 1'b1;
              state_d          = S_IDLE;
            end
            REQ_REPORT: begin
              if (sc_q != '0) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_kind = KIND_ENTRY;
                cmd_o.out_rank = 4'(sc_q - SC_W'(1));
                cmd_o.out_last = !sts_i.best_found;
              end else if (!sts_i.best_found) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_kind = KIND_EMPTY;
                cmd_o.out_last = 1'b1;
              end
              if (sts_i.best_found) begin
                cmd_o.rep_next = 1'b1;
                cmd_o.scan_clr = 1'b1;
                sc_d           = sc_q + SC_W'(1);
                idx_d          = '0;
                state_d        = (sc_q < SC_W'(TOP_COUNT - 1)) ? S_SCAN : S_FINISH;
              end else begin
                state_d = S_IDLE;
              end
            end
            default: begin
              kind_d  = KIND_DONE;
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      sc_q    <= '0;
      kind_q  <= KIND_DONE;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sc_q    <= sc_d;
      kind_q  <= kind_d;
    end
  end
endmodule
`default_nettype wire

### rtl/source_packet_counter_top_k_unit.sv
// Per-source packet counter with a ranked report. One request beat is taken
// at a time. Own-address and ignored-packet drops, clears, undo and a refused
// ignore go from dispatch straight to the result beat; a counted packet and
// an ignore command first sweep the table, since every lookup and every
// zeroing pass sweeps the count table through its single read port, one slot
// a cycle. A report sweeps the table once per ranked entry. Output stalls
// hold the result beat back. A new request is accepted while the previous
// result beat still waits in the output register.
`default_nettype none
`include "source_packet_counter_top_k_unit_macros.svh"
module source_packet_counter_top_k_unit import spctk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  spctk_req_if.sink        req_i,
  spctk_res_if.source      res_o
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence the sweeps and result beats
  spctk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the table, the ignore list and the output register
  spctk_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_i.req_type),
    .addr_i      (req_i.addr),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

  // Never overwrite a result beat that has not been taken
  `SPCTK_ASSERT_NOW(a_no_overwrite, cmd.out_load, !sts.out_busy)
  // Drop ready straight after a request is taken
  `SPCTK_ASSERT_NEXT(a_one_request, req_i.valid && req_i.ready, !req_i.ready)
  // An empty report is always the final beat
  `SPCTK_ASSERT_NOW(a_empty_last, res_o.valid && (res_o.kind == KIND_EMPTY), res_o.last)
endmodule
`default_nettype wire
